// File: hw/rtl/rcf_pkg.sv
// Shared constants and types for the replay counter filter.
`default_nettype none

package rcf_pkg;

  localparam int SLOTS    = 8;
  localparam int EID_BITS = 64;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int ID_W     = 64;
  localparam int CNT_W    = 32;
  localparam int ENT_W    = EID_BITS + CNT_W;
  localparam int IN_W     = ID_W + CNT_W;
  localparam int OUT_W    = 8;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic was_known;
    logic is_replay;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/rcf_ram.sv
// Simple dual-port RAM, one write and one registered read port.
`default_nettype none

module rcf_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 96
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/rcf_ctrl.sv
// Slot scan sequencer: valid bits, insert pointer, table memory read-modify-write.
`default_nettype none

module rcf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_op,
  input  wire logic [rcf_pkg::ID_W-1:0]  in_id,
  input  wire logic [rcf_pkg::CNT_W-1:0] in_cnt,
  output logic                     res_valid,
  input  wire logic                res_take,
  output rcf_pkg::res_t            res
);
  import rcf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  logic [1:0]          state;
  logic [SLOT_W-1:0]   scan_idx;
  logic [SLOT_W-1:0]   chk_idx;
  logic                chk_on;
  logic [SLOT_W-1:0]   ptr;
  logic [SLOTS-1:0]    slot_valid;
  logic [EID_BITS-1:0] key_id;
  logic [CNT_W-1:0]    key_cnt;

  logic                we;
  logic [SLOT_W-1:0]   waddr;
  logic [ENT_W-1:0]    rdata;
  logic [EID_BITS-1:0] rd_id;
  logic [CNT_W-1:0]    rd_cnt;
  logic                hit;
  logic                replay;
  logic                miss;

  rcf_ram #(
    .DEPTH (SLOTS),
    .WIDTH (ENT_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({key_id, key_cnt}),
    .raddr (scan_idx),
    .rdata (rdata)
  );

  assign rd_id  = rdata[ENT_W-1:CNT_W];
  assign rd_cnt = rdata[CNT_W-1:0];

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  assign hit    = (state == ST_SCAN) && chk_on && slot_valid[chk_idx] && (rd_id == key_id);
  assign replay = key_cnt <= rd_cnt;
  assign miss   = (state == ST_SCAN) && chk_on && !hit && (chk_idx == LAST_SLOT);

  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    if (hit && !replay) begin
      we    = 1'b1;
      waddr = chk_idx;
    end else if (miss) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_idx   <= '0;
      chk_idx    <= '0;
      chk_on     <= 1'b0;
      ptr        <= '0;
      slot_valid <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            chk_on   <= 1'b0;
            scan_idx <= '0;
            if (in_op == OP_CLEAR) begin
              slot_valid <= '0;
              ptr        <= '0;
              state      <= ST_DONE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          chk_idx <= scan_idx;
          if (scan_idx != LAST_SLOT) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (hit) begin
            chk_on <= 1'b0;
            state  <= ST_DONE;
          end else if (miss) begin
            chk_on          <= 1'b0;
            slot_valid[ptr] <= 1'b1;
            ptr             <= (ptr == LAST_SLOT) ? '0 : ptr + 1'b1;
            state           <= ST_DONE;
          end else begin
            chk_on <= 1'b1;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      key_id        <= in_id[EID_BITS-1:0];
      key_cnt       <= in_cnt;
      res.was_known <= 1'b0;
      res.is_replay <= 1'b0;
    end else if (hit) begin
      res.was_known <= 1'b1;
      res.is_replay <= replay;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/replay_counter_filter.sv
// Top level of the replay counter filter.
//
//   group  dir  tdata                                   tuser
//   s_*    in   [63:0] sender_id, [95:64] msg_count     [0] op (0 check, 1 clear)
//   m_*    out  [0] is_replay, [1] was_known, [7:2] 0   -
//
// One word at a time: a check word is scanned one slot per cycle through the
// table memory read port, up to all SLOTS slots; a hit ends the scan early.
// A clear skips the scan and goes straight to the result.
// Reset empties the table and zeroes the insert pointer at once.
// The output register lets the next word enter while a result is unread.
`default_nettype none

module replay_counter_filter (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [rcf_pkg::IN_W-1:0]  s_tdata,  // sender_id, msg_count
  input  wire logic [0:0]                s_tuser,  // op
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [rcf_pkg::OUT_W-1:0]      m_tdata   // is_replay, was_known, pad
);
  import rcf_pkg::*;

  logic res_valid;
  logic res_take;
  res_t res;

  assign res_take = res_valid && (!m_tvalid || m_tready);

  rcf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser[0]),
    .in_id     (s_tdata[ID_W-1:0]),
    .in_cnt    (s_tdata[IN_W-1:ID_W]),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= {{(OUT_W - 2){1'b0}}, res.was_known, res.is_replay};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rcf_chk.sv
// Port checker for the replay counter filter, bound to the top level.
`default_nettype none

module rcf_chk (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      s_tvalid,
  input wire logic                      s_tready,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [rcf_pkg::OUT_W-1:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_known: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && !m_tdata[1]))
    else $error("replay flagged for unknown sender");

  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a word is in work");

endmodule

bind replay_counter_filter rcf_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
